>>> rtl/rc4sc_pkg.sv
// Shared types, constants and the microcode program of the RC4 stream cipher.
package rc4sc_pkg;

  // Byte and key widths
  localparam int BYTE_W    = 8;
  localparam int KEY_LEN_W = 5;
  localparam int KEY_REG_W = 64;
  localparam int PC_W      = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd4;

  // Microcode addresses
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_B0    = 4'd1;
  localparam logic [PC_W-1:0] PC_B1    = 4'd2;
  localparam logic [PC_W-1:0] PC_B2    = 4'd3;
  localparam logic [PC_W-1:0] PC_B3    = 4'd4;
  localparam logic [PC_W-1:0] PC_B4    = 4'd5;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd6;
  localparam logic [PC_W-1:0] PC_SCHED = 4'd7;
  localparam logic [PC_W-1:0] PC_FILL  = 4'd8;
  localparam logic [PC_W-1:0] PC_K0    = 4'd9;
  localparam logic [PC_W-1:0] PC_K1    = 4'd10;
  localparam logic [PC_W-1:0] PC_K2    = 4'd11;
  localparam logic [PC_W-1:0] PC_K3    = 4'd12;
  localparam logic [PC_W-1:0] PC_END   = 4'd13;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_READ,
    MEM_WRITE
  } mem_op_t;

  typedef enum logic [1:0] {
    ADDR_I,
    ADDR_I_NEXT,
    ADDR_J,
    ADDR_J_SUM
  } addr_sel_t;

  // Address mode for the final keystream read is a separate bit (see addr_t)
  typedef enum logic [1:0] {
    WD_I,
    WD_SI,
    WD_SJ
  } wdata_sel_t;

  typedef enum logic [1:0] {
    IOP_HOLD,
    IOP_CLEAR,
    IOP_INC
  } i_op_t;

  typedef enum logic [1:0] {
    JOP_HOLD,
    JOP_CLEAR,
    JOP_SUM
  } j_op_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_CLEAR,
    POS_STEP
  } pos_op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_WAIT_IN,
    COND_WAIT_OUT,
    COND_I_NOT_LAST
  } cond_t;

  // One microcode word
  typedef struct packed {
    logic       accept;
    mem_op_t    mem_op;
    addr_sel_t  addr_sel;
    logic       addr_t;     // address is S[i] + S[j] (keystream lookup)
    wdata_sel_t wdata_sel;
    logic       lat_si;
    logic       lat_sj;
    i_op_t      i_op;
    j_op_t      j_op;
    logic       key_add;    // add the current key byte into the j sum
    pos_op_t    pos_op;
    logic       set_keyed;
    logic       load_out;
    cond_t      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic need_key;
    logic out_busy;
    logic i_last;
  } stat_t;

  // Microcode program
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      PC_IDLE: begin
        c.accept = 1'b1;
        c.cond   = COND_WAIT_IN;
        c.target = PC_SCHED;
      end
      // read S[i+1], step i
      PC_B0: begin
        c.mem_op   = MEM_READ;
        c.addr_sel = ADDR_I_NEXT;
        c.i_op     = IOP_INC;
      end
      // j += S[i], read S[j]
      PC_B1: begin
        c.lat_si   = 1'b1;
        c.j_op     = JOP_SUM;
        c.mem_op   = MEM_READ;
        c.addr_sel = ADDR_J_SUM;
      end
      PC_B2: begin
        c.lat_sj    = 1'b1;
        c.mem_op    = MEM_WRITE;
        c.addr_sel  = ADDR_J;
        c.wdata_sel = WD_SI;
      end
      PC_B3: begin
        c.mem_op    = MEM_WRITE;
        c.addr_sel  = ADDR_I;
        c.wdata_sel = WD_SJ;
      end
      PC_B4: begin
        c.mem_op = MEM_READ;
        c.addr_t = 1'b1;
      end
      PC_OUT: begin
        c.load_out = 1'b1;
        c.cond     = COND_WAIT_OUT;
        c.target   = PC_IDLE;
      end
      PC_SCHED: begin
        c.i_op   = IOP_CLEAR;
        c.j_op   = JOP_CLEAR;
        c.pos_op = POS_CLEAR;
      end
      // identity fill
      PC_FILL: begin
        c.mem_op    = MEM_WRITE;
        c.addr_sel  = ADDR_I;
        c.wdata_sel = WD_I;
        c.i_op      = IOP_INC;
        c.cond      = COND_I_NOT_LAST;
        c.target    = PC_FILL;
      end
      // keyed swap loop
      PC_K0: begin
        c.mem_op   = MEM_READ;
        c.addr_sel = ADDR_I;
      end
      PC_K1: begin
        c.lat_si   = 1'b1;
        c.j_op     = JOP_SUM;
        c.key_add  = 1'b1;
        c.mem_op   = MEM_READ;
        c.addr_sel = ADDR_J_SUM;
      end
      PC_K2: begin
        c.lat_sj    = 1'b1;
        c.mem_op    = MEM_WRITE;
        c.addr_sel  = ADDR_J;
        c.wdata_sel = WD_SI;
      end
      PC_K3: begin
        c.mem_op    = MEM_WRITE;
        c.addr_sel  = ADDR_I;
        c.wdata_sel = WD_SJ;
        c.i_op      = IOP_INC;
        c.pos_op    = POS_STEP;
        c.cond      = COND_I_NOT_LAST;
        c.target    = PC_K0;
      end
      PC_END: begin
        c.j_op      = JOP_CLEAR;
        c.set_keyed = 1'b1;
        c.cond      = COND_JUMP;
        c.target    = PC_B0;
      end
      default: begin
        c.cond   = COND_JUMP;
        c.target = PC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/rc4sc_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module rc4sc_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  rc4sc_pkg::stat_t stat,
  output rc4sc_pkg::ctrl_t ctrl
);

  logic [rc4sc_pkg::PC_W-1:0] pc;
  logic [rc4sc_pkg::PC_W-1:0] pc_next;
  logic [rc4sc_pkg::PC_W-1:0] pc_inc;

  assign ctrl   = rc4sc_pkg::ucode(pc);
  assign pc_inc = pc + 1'b1;

  // Next step selection
  always_comb begin
    case (ctrl.cond)
      rc4sc_pkg::COND_NEXT:       pc_next = pc_inc;
      rc4sc_pkg::COND_JUMP:       pc_next = ctrl.target;
      rc4sc_pkg::COND_WAIT_IN:    pc_next = !in_valid     ? pc :
                                            stat.need_key ? ctrl.target : pc_inc;
      rc4sc_pkg::COND_WAIT_OUT:   pc_next = stat.out_busy ? pc : ctrl.target;
      rc4sc_pkg::COND_I_NOT_LAST: pc_next = stat.i_last ? pc_inc : ctrl.target;
      default:                    pc_next = rc4sc_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rc4sc_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/rc4sc_dp.sv
// Datapath: permutation memory, index registers, key registers and output register.
module rc4sc_dp #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rc4sc_pkg::ctrl_t                    ctrl,
  output rc4sc_pkg::stat_t                    stat,
  input  logic                                in_valid,
  input  logic [rc4sc_pkg::BYTE_W-1:0]        in_byte,
  input  logic                                in_first,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rc4sc_pkg::BYTE_W-1:0]        out_byte,
  input  logic                                cfg_valid,
  input  logic [rc4sc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rc4sc_pkg::KEY_REG_W-1:0]     cfg_data
);

  localparam int POS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int BW    = rc4sc_pkg::BYTE_W;
  localparam int LW    = rc4sc_pkg::KEY_LEN_W;

  logic [BW-1:0] sbox [0:(1<<BW)-1];
  logic [BW-1:0] rd;
  logic [BW-1:0] i;
  logic [BW-1:0] j;
  logic [BW-1:0] si;
  logic [BW-1:0] sj;
  logic [BW-1:0] data;
  logic [POS_W-1:0] pos;
  logic          keyed;
  logic [rc4sc_pkg::KEY_REG_W-1:0] key_low;
  logic [rc4sc_pkg::KEY_REG_W-1:0] key_high;
  logic [LW-1:0] key_length;

  logic [2*rc4sc_pkg::KEY_REG_W-1:0] key_all;
  logic [BW-1:0] key_byte;
  logic [BW-1:0] j_sum;
  logic [BW-1:0] addr;
  logic [BW-1:0] wdata;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] pos_inc;
  logic [POS_W-1:0] pos_next;
  logic          in_take;
  logic          out_load;

  // Key byte for the schedule, length clamped to 1..MAX_KEY_BYTES
  assign key_all  = {key_high, key_low};
  assign key_byte = key_all[{pos, 3'b000} +: BW];
  assign len_eff  = (key_length == '0) ? LW'(1) :
                    (key_length > LW'(MAX_KEY_BYTES)) ? LW'(MAX_KEY_BYTES) : key_length;
  assign pos_inc  = LW'(pos) + LW'(1);
  assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];

  // j update sum, also used as the read address of S[j]
  assign j_sum = j + rd + (ctrl.key_add ? key_byte : '0);

  // Memory address and write data
  always_comb begin
    if (ctrl.addr_t) begin
      addr = si + sj;
    end else begin
      case (ctrl.addr_sel)
        rc4sc_pkg::ADDR_I:      addr = i;
        rc4sc_pkg::ADDR_I_NEXT: addr = i + 1'b1;
        rc4sc_pkg::ADDR_J:      addr = j;
        rc4sc_pkg::ADDR_J_SUM:  addr = j_sum;
        default:                addr = i;
      endcase
    end
    case (ctrl.wdata_sel)
      rc4sc_pkg::WD_I:  wdata = i;
      rc4sc_pkg::WD_SI: wdata = si;
      rc4sc_pkg::WD_SJ: wdata = sj;
      default:          wdata = i;
    endcase
  end

  assign in_take  = in_valid && ctrl.accept;
  assign out_load = ctrl.load_out && !stat.out_busy;

  assign stat.need_key = in_first || !keyed;
  assign stat.out_busy = out_valid && !out_ready;
  assign stat.i_last   = (i == '1);

  // Permutation memory, single port, registered read
  always_ff @(posedge clk) begin
    if (ctrl.mem_op == rc4sc_pkg::MEM_WRITE) begin
      sbox[addr] <= wdata;
    end
    if (ctrl.mem_op == rc4sc_pkg::MEM_READ) begin
      rd <= sbox[addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.lat_si) begin
      si <= rd;
    end
    if (ctrl.lat_sj) begin
      sj <= rd;
    end
    if (in_take) begin
      data <= in_byte;
    end
    if (out_load) begin
      out_byte <= data ^ rd;
    end
    case (ctrl.pos_op)
      rc4sc_pkg::POS_CLEAR: pos <= '0;
      rc4sc_pkg::POS_STEP:  pos <= pos_next;
      default:              pos <= pos;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      i          <= '0;
      j          <= '0;
      keyed      <= 1'b0;
      out_valid  <= 1'b0;
      key_low    <= '0;
      key_high   <= '0;
      key_length <= rc4sc_pkg::KEY_LEN_RESET;
    end else begin
      case (ctrl.i_op)
        rc4sc_pkg::IOP_CLEAR: i <= '0;
        rc4sc_pkg::IOP_INC:   i <= i + 1'b1;
        default:              i <= i;
      endcase
      case (ctrl.j_op)
        rc4sc_pkg::JOP_CLEAR: j <= '0;
        rc4sc_pkg::JOP_SUM:   j <= j_sum;
        default:              j <= j;
      endcase
      if (ctrl.set_keyed) begin
        keyed <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          rc4sc_pkg::REG_KEY_LOW:    key_low    <= cfg_data;
          rc4sc_pkg::REG_KEY_HIGH:   key_high   <= cfg_data;
          rc4sc_pkg::REG_KEY_LENGTH: key_length <= cfg_data[LW-1:0];
          default:                   key_length <= key_length;
        endcase
      end
    end
  end

endmodule

>>> rtl/rc4_stream_cipher_top.sv
// RC4 stream cipher top level: microcode sequencer plus datapath.
// On a keyed stream each byte runs IDLE (input taken), B0 to B4 (reads and swap writes
// on the single memory port) and OUT (output register loaded); a new byte is taken only
// back in IDLE, and OUT waits while the output is held. A byte flagged first, or the
// first byte after reset, adds the key schedule: clear, identity fill, keyed swap loop, end.
// Reset clears indexes, keyed flag, key words and output valid and sets key length to 4.
module rc4_stream_cipher_top #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  rc4sc_pkg::ctrl_t ctrl;
  rc4sc_pkg::stat_t stat;

  // no transaction is taken while reset is held
  assign s_axis_tready = ctrl.accept && !rst;
  assign cfg_ready     = !rst;

  rc4sc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rc4sc_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_valid  (s_axis_tvalid),
    .in_byte   (s_axis_tdata),
    .in_first  (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
